/* hw/rtl/pca_pkg.sv */
// ---------------------------------------------------------------------------
// pca_pkg
// Shared constants and payload types of the peak centroid accumulator.
// ---------------------------------------------------------------------------
`default_nettype none

package pca_pkg;

    // Default configuration of the accumulator.
    localparam int MAX_SAMPLES   = 512;
    localparam int FRACTION_BITS = 8;

    // Fixed field widths of the input and result items.
    localparam int SAMPLE_BITS  = 12;
    localparam int COLUMN_W     = 8;
    localparam int BUCKET_W     = 9;
    localparam int PEAK_SUM_W   = 21;
    localparam int CENTROID_W   = 17;
    localparam int COUNT_OUT_W  = 10;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic [COLUMN_W-1:0]    pad_column;
        logic [BUCKET_W-1:0]    time_bucket;
        logic                   last_sample;
    } t_in_item;

    typedef struct packed {
        logic [PEAK_SUM_W-1:0]  peak_sum;
        logic [CENTROID_W-1:0]  centroid;
        logic [SAMPLE_BITS-1:0] max_value;
        logic [COLUMN_W-1:0]    max_column;
        logic [BUCKET_W-1:0]    max_bucket;
        logic [SAMPLE_BITS-1:0] min_value;
        logic [COUNT_OUT_W-1:0] sample_count;
        logic                   zero_sum;
        logic                   overflowed;
    } t_out_item;

endpackage

`default_nettype wire

/* hw/rtl/pca_divider.sv */
// ---------------------------------------------------------------------------
// pca_divider
// Restoring divider, one quotient bit per cycle, for the centroid division.
// ---------------------------------------------------------------------------
`default_nettype none

module pca_divider #(
    parameter int NUM_W = 38,
    parameter int DEN_W = 22
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_busy,
    output logic                  o_done,
    output logic [NUM_W-1:0]      o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [NUM_W-1:0] r_quo;

    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             fits;
    logic [DEN_W-1:0] n_rem;
    logic [NUM_W-1:0] n_quo;

    // One compare and subtract per cycle on the partial remainder.
    always_comb begin
        shifted = {r_rem, r_quo[NUM_W-1]};
        diff    = shifted - {1'b0, r_den};
        fits    = (shifted >= {1'b0, r_den});
        n_rem   = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
        n_quo   = {r_quo[NUM_W-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_rem <= '0;
            r_den <= i_den;
            r_quo <= i_num;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quo;

    // The remainder of a restoring division stays below the divisor.
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_den != '0) |-> (r_rem < r_den))
        else $error("divider remainder not below divisor");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a running division");

    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_busy) |-> (r_cnt == CNT_W'(NUM_W)))
        else $error("divider started with a wrong step count");

endmodule

`default_nettype wire

/* hw/rtl/peak_centroid_accumulator.sv */
// ---------------------------------------------------------------------------
// peak_centroid_accumulator
// Accumulates the samples of one detector peak and, on the last sample,
// reports sum, extremes, count and the charge-weighted centroid.
// ---------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                 Payload
//   input     in         i_in_valid / o_in_ready   i_in_data  (t_in_item)
//   result    out        o_out_valid / i_out_ready o_out_data (t_out_item)
//
// A sample without the last flag is accumulated while o_in_ready stays high.
// A closing sample starts the restoring divider, which produces one quotient bit
// per cycle; the output register is then loaded, and o_in_ready stays low until
// the division has ended and its result has moved to the output register.
// A result still waiting on i_out_ready when a division ends holds the block
// until that result has been transferred.
// Reset is synchronous and active low; it clears all accumulators.
// ---------------------------------------------------------------------------
`default_nettype none

module peak_centroid_accumulator #(
    parameter int MAX_SAMPLES   = pca_pkg::MAX_SAMPLES,
    parameter int FRACTION_BITS = pca_pkg::FRACTION_BITS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire pca_pkg::t_in_item i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output pca_pkg::t_out_item     o_out_data
);

    import pca_pkg::*;

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W = SAMPLE_BITS + CNT_W;
    localparam int WS_W  = SAMPLE_BITS + 2 * CNT_W;
    localparam int PRD_W = SAMPLE_BITS + CNT_W;
    localparam int NUM_W = WS_W + FRACTION_BITS;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]             r_state;
    logic [SUM_W-1:0]       r_sum;
    logic [WS_W-1:0]        r_wsum;
    logic [CNT_W-1:0]       r_count;
    logic [SAMPLE_BITS-1:0] r_max;
    logic [COLUMN_W-1:0]    r_max_col;
    logic [BUCKET_W-1:0]    r_max_bkt;
    logic [SAMPLE_BITS-1:0] r_min;
    logic                   r_dropped;
    logic                   r_out_valid;
    t_out_item              r_pend;
    t_out_item              r_out_data;

    logic [SUM_W-1:0]       n_sum;
    logic [WS_W-1:0]        n_wsum;
    logic [CNT_W-1:0]       n_count;
    logic [SAMPLE_BITS-1:0] n_max;
    logic [COLUMN_W-1:0]    n_max_col;
    logic [BUCKET_W-1:0]    n_max_bkt;
    logic [SAMPLE_BITS-1:0] n_min;
    logic                   n_dropped;
    t_out_item              n_pend;
    t_out_item              n_out_data;

    logic [PRD_W-1:0]       product;
    logic                   full;
    logic                   in_xfer;
    logic                   slot_free;
    logic                   out_load;
    logic                   div_start;
    logic                   div_busy;
    logic                   div_done;
    logic [NUM_W-1:0]       div_num;
    logic [NUM_W-1:0]       div_quot;
    logic                   cent_sat;

    assign in_xfer   = i_in_valid && o_in_ready;
    assign slot_free = !r_out_valid || i_out_ready;
    assign full      = (r_count >= CNT_W'(MAX_SAMPLES));
    assign product   = PRD_W'(i_in_data.sample) * PRD_W'(r_count);

    // The finished centroid moves to the output register once the slot is free.
    assign out_load  = slot_free &&
                       (((r_state == ST_DIV) && div_done) || (r_state == ST_HOLD));

    // Accumulator update for the sample on the input port.
    always_comb begin
        n_sum     = r_sum;
        n_wsum    = r_wsum;
        n_count   = r_count;
        n_max     = r_max;
        n_max_col = r_max_col;
        n_max_bkt = r_max_bkt;
        n_min     = r_min;
        n_dropped = r_dropped;
        if (full) begin
            n_dropped = 1'b1;
        end else begin
            n_sum   = r_sum + SUM_W'(i_in_data.sample);
            n_wsum  = r_wsum + WS_W'(product);
            n_count = r_count + 1'b1;
            // Only a strictly greater sample moves the recorded position.
            if (i_in_data.sample > r_max) begin
                n_max     = i_in_data.sample;
                n_max_col = i_in_data.pad_column;
                n_max_bkt = i_in_data.time_bucket;
            end
            if (i_in_data.sample < r_min) begin
                n_min = i_in_data.sample;
            end
        end
    end

    always_comb begin
        n_pend              = '0;
        n_pend.peak_sum     = PEAK_SUM_W'(n_sum);
        n_pend.max_value    = n_max;
        n_pend.max_column   = n_max_col;
        n_pend.max_bucket   = n_max_bkt;
        n_pend.min_value    = n_min;
        n_pend.sample_count = COUNT_OUT_W'(n_count);
        n_pend.zero_sum     = (n_sum == '0);
        n_pend.overflowed   = n_dropped;
    end

    assign div_start = in_xfer && i_in_data.last_sample;
    assign div_num   = NUM_W'(n_wsum) << FRACTION_BITS;

    pca_divider #(
        .NUM_W (NUM_W),
        .DEN_W (SUM_W)
    ) u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (n_sum),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // A quotient wider than the centroid field saturates; a zero sum gives 0.
    assign cent_sat = |(div_quot >> CENTROID_W);

    always_comb begin
        n_out_data = r_pend;
        if (r_pend.zero_sum) begin
            n_out_data.centroid = '0;
        end else if (cent_sat) begin
            n_out_data.centroid = '1;
        end else begin
            n_out_data.centroid = CENTROID_W'(div_quot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_sum       <= '0;
            r_wsum      <= '0;
            r_count     <= '0;
            r_max       <= '0;
            r_max_col   <= '0;
            r_max_bkt   <= '0;
            r_min       <= '1;
            r_dropped   <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        if (i_in_data.last_sample) begin
                            r_sum     <= '0;
                            r_wsum    <= '0;
                            r_count   <= '0;
                            r_max     <= '0;
                            r_max_col <= '0;
                            r_max_bkt <= '0;
                            r_min     <= '1;
                            r_dropped <= 1'b0;
                            r_state   <= ST_DIV;
                        end else begin
                            r_sum     <= n_sum;
                            r_wsum    <= n_wsum;
                            r_count   <= n_count;
                            r_max     <= n_max;
                            r_max_col <= n_max_col;
                            r_max_bkt <= n_max_bkt;
                            r_min     <= n_min;
                            r_dropped <= n_dropped;
                        end
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        if (slot_free) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_state <= ST_HOLD;
                        end
                    end
                end
                ST_HOLD: begin
                    if (slot_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (div_start) begin
            r_pend <= n_pend;
        end
        if (out_load) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_ready_not_dividing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !div_busy)
        else $error("input ready while the divider is running");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_SAMPLES))
        else $error("sample count above its limit");

    a_cleared_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_in_data.last_sample) |=>
            (r_count == '0 && r_sum == '0 && r_wsum == '0 && !r_dropped))
        else $error("accumulators not cleared after a closing transfer");

    a_result_from_division: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_DIV || $past(r_state) == ST_HOLD))
        else $error("result raised without a finished division");

endmodule

`default_nettype wire
